>>> hdl/dfr_pkg.sv
// Shared types, register codes and helpers for the DLE frame receiver.
package dfr_pkg;

  localparam int unsigned DefFrameLimit = 1024;
  localparam int unsigned ByteW = 8;
  localparam int unsigned PosOutW = 10;
  localparam int unsigned KindW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SatInW = 13;

  // Result kinds carried on the output channel.
  typedef enum logic [KindW-1:0] {
    KIND_DATA     = 3'd0,
    KIND_OK       = 3'd1,
    KIND_ACK      = 3'd2,
    KIND_NAK      = 3'd3,
    KIND_LEN_ERR  = 3'd4,
    KIND_SUM_ERR  = 3'd5,
    KIND_OVERFLOW = 3'd6
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_ESCAPE = 2'd0,
    REG_END    = 2'd1,
    REG_ACK_ID = 2'd2,
    REG_NAK_ID = 2'd3
  } cfg_reg_e;

  localparam logic [ByteW-1:0] EscapeReset = 8'd16;
  localparam logic [ByteW-1:0] EndReset    = 8'd3;
  localparam logic [ByteW-1:0] AckIdReset  = 8'd6;
  localparam logic [ByteW-1:0] NakIdReset  = 8'd21;

  // Clamp a count or position to the width of the output fields.
  function automatic logic [PosOutW-1:0] sat_pos(input logic [SatInW-1:0] v);
    logic [SatInW-1:0] lim;
    lim = SatInW'((1 << PosOutW) - 1);
    if (v > lim) begin
      return PosOutW'(lim);
    end
    return PosOutW'(v);
  endfunction

endpackage

>>> hdl/dfr_if.sv
// Valid/ready channel interfaces for raw input bytes and receiver results.
interface dfr_in_if import dfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dfr_out_if import dfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [ByteW-1:0]   data_byte;
  logic [PosOutW-1:0] byte_position;
  logic               frame_start;
  logic [ByteW-1:0]   frame_id;
  logic [PosOutW-1:0] frame_length;

  modport source (
    output valid, output kind, output data_byte, output byte_position,
    output frame_start, output frame_id, output frame_length, input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input byte_position,
    input frame_start, input frame_id, input frame_length, output ready
  );
endinterface

>>> hdl/dle_frame_receiver.sv
// Byte-stuffed frame receiver: unstuffs frame bytes and checks each frame.
//
// Raw link bytes arrive on rx_i, one request per byte. Each byte updates the
// escape flag, the hunt flag, the frame position, the saved id and length
// bytes and the running checksum in the same cycle, and at most one result
// goes into the output register: a data byte, or a verdict (ok, ack, nak,
// length error, checksum error, overflow) at escape+end or when a frame
// reaches FRAME_LIMIT bytes. Bytes that cause no result leave nothing behind.
// The result of an accepted byte is on res_o in the next cycle, and a byte can
// be accepted every cycle while res_o does not stall; the single result register
// sets both. When res_o stalls, rx_i stays ready while the result register is
// empty or being drained in the same cycle, so a held result stalls the input.
// Reset clears the flags, position and checksum, empties the result register
// and restores the register defaults (escape 16, end 3, ack 6, nak 21).
// Configuration writes through cfg_we_i/cfg_idx_i/cfg_data_i take effect at
// once and are meant for idle periods.
module dle_frame_receiver import dfr_pkg::*; #(
  parameter int unsigned FRAME_LIMIT = DefFrameLimit
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  dfr_in_if.sink             rx_i,
  dfr_out_if.source          res_o
);

  localparam int unsigned PosW = $clog2(FRAME_LIMIT);
  localparam int unsigned CntW = PosW + 1;
  localparam int unsigned CmpW = ((PosW > ByteW) ? PosW : ByteW) + 1;

  // Configuration registers.
  logic [ByteW-1:0] escape_q, end_q, ack_id_q, nak_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q <= EscapeReset;
      end_q    <= EndReset;
      ack_id_q <= AckIdReset;
      nak_id_q <= NakIdReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ESCAPE: escape_q <= cfg_data_i;
        REG_END:    end_q    <= cfg_data_i;
        REG_ACK_ID: ack_id_q <= cfg_data_i;
        REG_NAK_ID: nak_id_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Deframer state.
  logic            esc_q, esc_d;
  logic            hunt_q, hunt_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [ByteW-1:0] first_q, first_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] sum_q, sum_d;

  // Result register.
  logic               vld_q;
  kind_e              kind_q, kind_d;
  logic [ByteW-1:0]   data_q, data_d;
  logic [PosOutW-1:0] bpos_q, bpos_d;
  logic               start_q, start_d;
  logic [ByteW-1:0]   fid_q, fid_d;
  logic [PosOutW-1:0] flen_q, flen_d;
  logic               emit;

  logic             accept;
  logic [ByteW-1:0] b;
  logic             esc_hit, end_hit;
  logic             do_store, do_verdict, restart;
  logic [PosW-1:0]  spos;
  logic [CntW-1:0]  npos;
  logic [ByteW-1:0] first_new;
  logic [CmpW-1:0]  len_plus3;

  assign rx_i.ready = !vld_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign esc_hit    = (b == escape_q);
  assign end_hit    = (b == end_q);

  always_comb begin
    esc_d   = esc_q;
    hunt_d  = hunt_q;
    pos_d   = pos_q;
    first_d = first_q;
    len_d   = len_q;
    sum_d   = sum_q;

    kind_d  = KIND_DATA;
    data_d  = '0;
    bpos_d  = '0;
    start_d = 1'b0;
    fid_d   = '0;
    flen_d  = '0;

    do_store   = 1'b0;
    do_verdict = 1'b0;
    restart    = 1'b0;

    // Classify the byte; the escape role wins over the end role.
    if (esc_hit) begin
      if (hunt_q) begin
        hunt_d = 1'b0;
        pos_d  = '0;
        esc_d  = 1'b1;
      end else if (esc_q) begin
        esc_d    = 1'b0;
        do_store = 1'b1;
      end else begin
        esc_d = 1'b1;
      end
    end else if (end_hit) begin
      if (esc_q) begin
        do_verdict = 1'b1;
      end else if (!hunt_q) begin
        do_store = 1'b1;
      end
    end else if (!hunt_q) begin
      // An escape followed by any other byte opens a new frame.
      restart  = esc_q;
      esc_d    = 1'b0;
      do_store = 1'b1;
    end

    spos      = restart ? '0 : pos_q;
    npos      = CntW'(spos) + CntW'(1);
    first_new = (spos == '0) ? b : first_q;
    len_plus3 = CmpW'(len_q) + CmpW'(3);

    if (do_store) begin
      first_d = first_new;
      sum_d   = (spos == '0) ? b : ByteW'(sum_q + b);
      if (spos == PosW'(1)) begin
        len_d = b;
      end
      if (npos == CntW'(FRAME_LIMIT)) begin
        kind_d = KIND_OVERFLOW;
        fid_d  = first_new;
        flen_d = sat_pos(SatInW'(npos));
        hunt_d = 1'b1;
        pos_d  = '0;
        esc_d  = 1'b0;
      end else begin
        pos_d   = PosW'(npos);
        data_d  = b;
        bpos_d  = sat_pos(SatInW'(spos));
        start_d = (spos == '0);
      end
    end

    if (do_verdict) begin
      if (pos_q == '0) begin
        kind_d = KIND_LEN_ERR;
      end else if (first_q == ack_id_q) begin
        kind_d = KIND_ACK;
      end else if (first_q == nak_id_q) begin
        kind_d = KIND_NAK;
      end else if (len_plus3 != CmpW'(pos_q)) begin
        // Also covers frames shorter than three bytes.
        kind_d = KIND_LEN_ERR;
      end else if (sum_q != '0) begin
        kind_d = KIND_SUM_ERR;
      end else begin
        kind_d = KIND_OK;
      end
      fid_d  = (pos_q == '0) ? '0 : first_q;
      flen_d = sat_pos(SatInW'(pos_q));
      hunt_d = 1'b1;
      pos_d  = '0;
      esc_d  = 1'b0;
    end
  end

  assign emit = do_store || do_verdict;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= 1'b0;
      hunt_q  <= 1'b0;
      pos_q   <= '0;
      first_q <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (accept) begin
        esc_q   <= esc_d;
        hunt_q  <= hunt_d;
        pos_q   <= pos_d;
        first_q <= first_d;
        len_q   <= len_d;
        sum_q   <= sum_d;
        vld_q   <= emit;
      end else if (res_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q  <= kind_d;
      data_q  <= data_d;
      bpos_q  <= bpos_d;
      start_q <= start_d;
      fid_q   <= fid_d;
      flen_q  <= flen_d;
    end
  end

  assign res_o.valid         = vld_q;
  assign res_o.kind          = kind_q;
  assign res_o.data_byte     = data_q;
  assign res_o.byte_position = bpos_q;
  assign res_o.frame_start   = start_q;
  assign res_o.frame_id      = fid_q;
  assign res_o.frame_length  = flen_q;

endmodule

>>> verif/tb_dle_frame_receiver.sv
// Self-checking testbench for the DLE frame receiver with a byte-level deframing predictor.
module tb_dle_frame_receiver;
  import dfr_pkg::*;

  localparam int unsigned FrameLimit = DefFrameLimit;
  localparam int unsigned PosMax = (1 << PosOutW) - 1;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    kind_e              kind;
    logic [ByteW-1:0]   data_byte;
    logic [PosOutW-1:0] byte_position;
    logic               frame_start;
    logic [ByteW-1:0]   frame_id;
    logic [PosOutW-1:0] frame_length;
  } rx_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  cfg_reg_e         cfg_idx_i;
  logic [ByteW-1:0] cfg_data_i;

  dfr_in_if  rx_if ();
  dfr_out_if res_if ();

  dle_frame_receiver #(.FRAME_LIMIT(FrameLimit)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Register values as the block should hold them.
  logic [ByteW-1:0] cfg_esc = EscapeReset;
  logic [ByteW-1:0] cfg_end = EndReset;
  logic [ByteW-1:0] cfg_ack = AckIdReset;
  logic [ByteW-1:0] cfg_nak = NakIdReset;

  // Deframer state mirrored by the predictor.
  bit               dle_seen = 1'b0;
  bit               hunt_on = 1'b0;
  int unsigned      unstuffed_cnt = 0;
  logic [ByteW-1:0] id_byte = '0;
  logic [ByteW-1:0] len_byte = '0;
  logic [ByteW-1:0] csum = '0;

  logic [ByteW-1:0] rx_stream_q [$];
  rx_result_t       frame_results_q [$];

  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned bytes_in = 0;
  int unsigned results_seen = 0;
  int unsigned verdicts_seen = 0;
  int unsigned overflows_seen = 0;

  bit          in_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  logic [7:0]  stall_pat = 8'b1011_0010;

  function automatic logic [PosOutW-1:0] cap_count(input int unsigned v);
    return (v > PosMax) ? PosOutW'(PosMax) : PosOutW'(v);
  endfunction

  task automatic start_hunt();
    hunt_on = 1'b1;
    unstuffed_cnt = 0;
    dle_seen = 1'b0;
  endtask

  // One unstuffed byte joins the frame; the byte that reaches the limit
  // turns into an overflow verdict instead of data.
  task automatic store_unstuffed(input logic [ByteW-1:0] b);
    int unsigned p;
    rx_result_t r;
    p = unstuffed_cnt;
    r = '0;
    if (p == 0) begin
      id_byte = b;
      csum = b;
    end else begin
      csum = csum + b;
    end
    if (p == 1) len_byte = b;
    unstuffed_cnt = p + 1;
    if (unstuffed_cnt >= FrameLimit) begin
      r.kind = KIND_OVERFLOW;
      r.frame_id = id_byte;
      r.frame_length = cap_count(unstuffed_cnt);
      start_hunt();
    end else begin
      r.kind = KIND_DATA;
      r.data_byte = b;
      r.byte_position = cap_count(p);
      r.frame_start = (p == 0);
    end
    frame_results_q.push_back(r);
  endtask

  task automatic close_frame();
    int unsigned n;
    rx_result_t r;
    n = unstuffed_cnt;
    r = '0;
    if (n == 0) r.kind = KIND_LEN_ERR;
    else if (id_byte == cfg_ack) r.kind = KIND_ACK;
    else if (id_byte == cfg_nak) r.kind = KIND_NAK;
    else if (n < 3 || 32'(len_byte) != n - 3) r.kind = KIND_LEN_ERR;
    else if (csum != '0) r.kind = KIND_SUM_ERR;
    else r.kind = KIND_OK;
    r.frame_id = (n == 0) ? '0 : id_byte;
    r.frame_length = cap_count(n);
    frame_results_q.push_back(r);
    start_hunt();
  endtask

  task automatic deframe_byte(input logic [ByteW-1:0] b);
    if (b == cfg_esc) begin
      if (hunt_on) begin
        hunt_on = 1'b0;
        unstuffed_cnt = 0;
        dle_seen = 1'b1;
      end else if (dle_seen) begin
        dle_seen = 1'b0;
        store_unstuffed(b);
      end else begin
        dle_seen = 1'b1;
      end
    end else if (b == cfg_end && (dle_seen || hunt_on)) begin
      // A stray end byte while hunting is dropped.
      if (dle_seen) close_frame();
    end else if (!hunt_on) begin
      // Escape followed by any other byte opens a new frame with it as id.
      if (dle_seen) begin
        unstuffed_cnt = 0;
        dle_seen = 1'b0;
      end
      store_unstuffed(b);
    end
  endtask

  task automatic check_result();
    rx_result_t got;
    rx_result_t want;
    got.kind = kind_e'(res_if.kind);
    got.data_byte = res_if.data_byte;
    got.byte_position = res_if.byte_position;
    got.frame_start = res_if.frame_start;
    got.frame_id = res_if.frame_id;
    got.frame_length = res_if.frame_length;
    results_seen++;
    if (got.kind != KIND_DATA) verdicts_seen++;
    if (got.kind == KIND_OVERFLOW) overflows_seen++;
    if (frame_results_q.size() == 0) begin
      if (mismatch_cnt < 10) begin
        $display("Unexpected result: kind=%0d data=%02h pos=%0d start=%0b id=%02h len=%0d",
                 got.kind, got.data_byte, got.byte_position, got.frame_start,
                 got.frame_id, got.frame_length);
      end
      mismatch_cnt++;
    end else begin
      want = frame_results_q.pop_front();
      if (got !== want) begin
        if (mismatch_cnt < 10) begin
          $display("Mismatch on result %0d at cycle %0d:", results_seen, cycle_cnt);
          $display("  expected kind=%0d data=%02h pos=%0d start=%0b id=%02h len=%0d",
                   want.kind, want.data_byte, want.byte_position, want.frame_start,
                   want.frame_id, want.frame_length);
          $display("  actual   kind=%0d data=%02h pos=%0d start=%0b id=%02h len=%0d",
                   got.kind, got.data_byte, got.byte_position, got.frame_start,
                   got.frame_id, got.frame_length);
        end
        mismatch_cnt++;
      end
    end
  endtask

  // Requests and results are both sampled at the rising edge.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) check_result();
      if (rx_if.valid && rx_if.ready) begin
        deframe_byte(rx_if.rx_byte);
        in_taken = 1'b1;
        bytes_in++;
      end
    end
  end

  // Byte sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        rx_if.valid <= 1'b0;
      end else if (rx_stream_q.size() != 0) begin
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= rx_stream_q.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: switches between no stalls, random, patterned and heavy stalls.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: begin
        res_if.ready <= 1'b1;
      end
      1: begin
        res_if.ready <= ($urandom_range(0, 9) < 7);
      end
      2: begin
        stall_pat = {stall_pat[6:0], stall_pat[7]};
        res_if.ready <= stall_pat[0];
      end
      default: begin
        res_if.ready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [ByteW-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    case (idx)
      REG_ESCAPE: cfg_esc = v;
      REG_END:    cfg_end = v;
      REG_ACK_ID: cfg_ack = v;
      default:    cfg_nak = v;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [ByteW-1:0] esc, input logic [ByteW-1:0] eb,
                          input logic [ByteW-1:0] ack, input logic [ByteW-1:0] nak);
    write_reg(REG_ESCAPE, esc);
    write_reg(REG_END, eb);
    write_reg(REG_ACK_ID, ack);
    write_reg(REG_NAK_ID, nak);
  endtask

  task automatic push_raw(input logic [ByteW-1:0] b);
    rx_stream_q.push_back(b);
  endtask

  task automatic push_stuffed(input logic [ByteW-1:0] b);
    push_raw(b);
    if (b == cfg_esc) push_raw(b);
  endtask

  task automatic push_close();
    push_raw(cfg_esc);
    push_raw(cfg_end);
  endtask

  function automatic logic [ByteW-1:0] pick_id();
    logic [ByteW-1:0] id;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    id = (sel == 0) ? cfg_ack : (sel == 1) ? cfg_nak : 8'($urandom);
    while (id == cfg_esc || id == cfg_end) id = 8'($urandom);
    return id;
  endfunction

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 49) == 0) ? $urandom_range(13, 120) : $urandom_range(0, 12);
  endfunction

  // Frame with a correct length byte and a closing checksum unless told to spoil them.
  task automatic push_frame(input int unsigned payload_len, input bit bad_len, input bit bad_sum);
    logic [ByteW-1:0] id;
    logic [ByteW-1:0] lb;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] d;
    id = pick_id();
    lb = 8'(payload_len);
    if (bad_len) lb = lb + 8'($urandom_range(1, 255));
    push_raw(cfg_esc);
    push_stuffed(id);
    push_stuffed(lb);
    sum = id + lb;
    repeat (payload_len) begin
      d = 8'($urandom);
      push_stuffed(d);
      sum = sum + d;
    end
    d = -sum;
    if (bad_sum) d = d + 8'($urandom_range(1, 255));
    push_stuffed(d);
    push_close();
  endtask

  task automatic push_long(input int unsigned n_bytes, input bit closed);
    push_raw(cfg_esc);
    push_stuffed(pick_id());
    repeat (n_bytes - 1) push_stuffed(8'($urandom));
    if (closed) push_close();
  endtask

  task automatic gen_random(input int unsigned n_items);
    int unsigned n_done;
    int unsigned sz0;
    int unsigned sel;
    n_done = 0;
    while (n_done < n_items) begin
      sz0 = rx_stream_q.size();
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        push_frame(pick_len(), 1'b0, 1'b0);
      end else if (sel < 55) begin
        push_frame(pick_len(), 1'b1, 1'b0);
      end else if (sel < 65) begin
        push_frame(pick_len(), 1'b0, 1'b1);
      end else if (sel < 73) begin
        // Frame too short for a length and checksum.
        push_raw(cfg_esc);
        push_stuffed(pick_id());
        if ($urandom_range(0, 1) == 1) push_stuffed(8'($urandom));
        push_close();
      end else if (sel < 81) begin
        // Frame cut off; the next escape and id restart at position zero.
        push_raw(cfg_esc);
        push_stuffed(pick_id());
        repeat ($urandom_range(0, 4)) push_stuffed(8'($urandom));
      end else if (sel < 90) begin
        repeat ($urandom_range(1, 5)) push_raw(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          push_raw(($urandom_range(0, 1) == 1) ? cfg_esc : 8'($urandom));
        end
      end
      // Line noise mostly falls into hunting and is not counted.
      if (sel < 81 || sel >= 90) n_done += rx_stream_q.size() - sz0;
    end
  endtask

  task automatic drain();
    while (rx_stream_q.size() != 0 || rx_if.valid || frame_results_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [ByteW-1:0] esc;
    logic [ByteW-1:0] eb;
    logic [ByteW-1:0] ack;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_ESCAPE;
    cfg_data_i = '0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Bytes before any frame are data from position zero.
    push_raw(8'h00);
    push_raw(8'hFF);
    push_close();
    push_raw(cfg_end);
    push_close();
    push_raw(cfg_esc);
    push_raw(cfg_ack);
    push_close();
    push_raw(cfg_esc);
    push_raw(cfg_nak);
    push_close();
    push_raw(cfg_esc);
    push_raw(8'h20);
    push_raw(cfg_esc);
    push_raw(8'h01);
    push_raw(8'h00);
    push_raw(8'h00);
    push_close();
    push_raw(cfg_esc);
    push_raw(8'h01);
    push_raw(8'h00);
    push_raw(8'hFF);
    push_close();
    gen_random(260);
    drain();

    set_regs(8'hFF, 8'h00, 8'hFE, 8'h01);
    gen_random(180);
    drain();

    set_regs(8'h00, 8'hFF, 8'h80, 8'h7F);
    gen_random(180);
    drain();

    // Equal ack and nak ids: the ack check comes first.
    esc = 8'($urandom);
    do eb = 8'($urandom); while (eb == esc);
    ack = 8'($urandom);
    set_regs(esc, eb, ack, ack);
    gen_random(150);
    drain();

    // Escape and end share one value, so the escape meaning wins.
    set_regs(8'h55, 8'h55, 8'h06, 8'h15);
    gen_random(40);
    drain();

    set_regs(EscapeReset, EndReset, AckIdReset, NakIdReset);
    push_long(FrameLimit, 1'b1);
    gen_random(40);
    drain();

    $display("Sent %0d link bytes under six register settings, with a frame at the size limit.",
             bytes_in);
    $display("Checked %0d results: %0d verdicts, %0d of them overflow; %0d mismatches.",
             results_seen, verdicts_seen, overflows_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("Timeout after %0d cycles, %0d bytes queued, %0d results outstanding.",
             cycle_cnt, rx_stream_q.size(), frame_results_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> dle_frame_receiver.f
hdl/dfr_pkg.sv
hdl/dfr_if.sv
hdl/dle_frame_receiver.sv
verif/tb_dle_frame_receiver.sv
